// ----- rtl/ueg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ultrasonic echo ranging gap detector.
// Holds the shared types, register codes and reset constants; no dependencies.
package ueg_pkg;

  localparam int TRIGGER_TICKS_DEF = 10;
  localparam int TIMER_BITS_DEF    = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int POLL_W     = 24;
  localparam int TMO_W      = 16;
  localparam int THR_W      = 16;
  localparam int CONF_W     = 8;
  localparam int WIDTH_W    = 16;
  localparam int RUN_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POLL    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 4'd3;

  localparam logic [POLL_W-1:0] POLL_RESET    = 24'd60000;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd30000;
  localparam logic [THR_W-1:0]  THRESH_RESET  = 16'd1740;
  localparam logic [CONF_W-1:0] CONFIRM_RESET = 8'd3;

  localparam logic [RUN_W-1:0]   GAP_RUN_MAX = 8'hFF;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [POLL_W-1:0] poll_interval_ticks;
    logic [TMO_W-1:0]  echo_timeout_ticks;
    logic [THR_W-1:0]  gap_pulse_threshold;
    logic [CONF_W-1:0] gap_confirm_count;
  } cfg_t;

  typedef struct packed {
    logic               trigger_level;
    logic               reading_done;
    logic [WIDTH_W-1:0] echo_width_us;
    logic               echo_timed_out;
    logic [RUN_W-1:0]   gap_run_length;
    logic               gap_detected;
  } res_t;

endpackage

// ----- rtl/ueg_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces for the echo ranging gap detector: tick samples,
// results and configuration writes. Widths come from ueg_pkg.
interface ueg_sample_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface ueg_result_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger_level;
  logic                        reading_done;
  logic [ueg_pkg::WIDTH_W-1:0] echo_width_us;
  logic                        echo_timed_out;
  logic [ueg_pkg::RUN_W-1:0]   gap_run_length;
  logic                        gap_detected;

  modport source (output valid, output trigger_level, output reading_done,
                  output echo_width_us, output echo_timed_out,
                  output gap_run_length, output gap_detected, input ready);
  modport sink (input valid, input trigger_level, input reading_done,
                input echo_width_us, input echo_timed_out,
                input gap_run_length, input gap_detected, output ready);
endinterface

interface ueg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ueg_pkg::CFG_IDX_W-1:0]  index;
  logic [ueg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ueg_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file for the echo ranging gap detector.
// Depends on ueg_pkg for register codes, widths and reset values.
module ueg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [ueg_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ueg_pkg::CFG_DATA_W-1:0] wr_data,
  output ueg_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ticks <= ueg_pkg::POLL_RESET;
      cfg.echo_timeout_ticks  <= ueg_pkg::TIMEOUT_RESET;
      cfg.gap_pulse_threshold <= ueg_pkg::THRESH_RESET;
      cfg.gap_confirm_count   <= ueg_pkg::CONFIRM_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ueg_pkg::REG_POLL: begin
          cfg.poll_interval_ticks <= wr_data[ueg_pkg::POLL_W-1:0];
        end
        ueg_pkg::REG_TIMEOUT: begin
          cfg.echo_timeout_ticks <= wr_data[ueg_pkg::TMO_W-1:0];
        end
        ueg_pkg::REG_THRESH: begin
          cfg.gap_pulse_threshold <= wr_data[ueg_pkg::THR_W-1:0];
        end
        ueg_pkg::REG_CONFIRM: begin
          cfg.gap_confirm_count <= wr_data[ueg_pkg::CONF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/ueg_core.sv -----
`timescale 1ns / 1ps
// Ranging sequencer: phase state machine, saturating phase timer and gap run
// counter. Depends on ueg_pkg; produces one result per accepted tick.
module ueg_core #(
  parameter int TRIGGER_TICKS = ueg_pkg::TRIGGER_TICKS_DEF,
  parameter int TIMER_BITS    = ueg_pkg::TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          echo_level,
  input  ueg_pkg::cfg_t cfg,
  output ueg_pkg::res_t res
);

  localparam int CMP_W = (TIMER_BITS > ueg_pkg::POLL_W) ? TIMER_BITS : ueg_pkg::POLL_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [CMP_W-1:0] TRIG_END = CMP_W'(TRIGGER_TICKS);

  ueg_pkg::phase_t              phase, phase_next;
  logic [TIMER_BITS-1:0]        phase_ticks, phase_ticks_next;
  logic [ueg_pkg::RUN_W-1:0]    gap_run, gap_run_next;
  logic                         gap_flag, gap_flag_next;
  logic [TIMER_BITS-1:0]        elapsed;
  logic [CMP_W-1:0]             elapsed_ext;
  logic                         done;
  logic                         tmo;
  logic [ueg_pkg::WIDTH_W-1:0]  width;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ueg_pkg::PH_IDLE;
      phase_ticks <= '0;
      gap_run     <= '0;
      gap_flag    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      phase_ticks <= phase_ticks_next;
      gap_run     <= gap_run_next;
      gap_flag    <= gap_flag_next;
    end
  end

  assign elapsed     = (phase_ticks == TIMER_MAX) ? phase_ticks : phase_ticks + 1'b1;
  assign elapsed_ext = CMP_W'(elapsed);

  always_comb begin
    phase_next       = phase;
    phase_ticks_next = elapsed;
    gap_run_next     = gap_run;
    gap_flag_next    = gap_flag;
    done             = 1'b0;
    tmo              = 1'b0;
    width            = '0;
    unique case (phase)
      ueg_pkg::PH_IDLE: begin
        if (elapsed_ext >= CMP_W'(cfg.poll_interval_ticks)) begin
          phase_next       = ueg_pkg::PH_TRIG;
          phase_ticks_next = '0;
        end
      end
      ueg_pkg::PH_TRIG: begin
        if (elapsed_ext >= TRIG_END) begin
          phase_next       = ueg_pkg::PH_RISE;
          phase_ticks_next = '0;
        end
      end
      ueg_pkg::PH_RISE: begin
        if (echo_level) begin
          phase_next       = ueg_pkg::PH_FALL;
          phase_ticks_next = '0;
        end else if (elapsed_ext >= CMP_W'(cfg.echo_timeout_ticks)) begin
          tmo              = 1'b1;
          phase_next       = ueg_pkg::PH_IDLE;
          phase_ticks_next = '0;
        end
      end
      ueg_pkg::PH_FALL: begin
        if (!echo_level) begin
          done  = 1'b1;
          width = (|elapsed_ext[CMP_W-1:ueg_pkg::WIDTH_W]) ? ueg_pkg::WIDTH_MAX
                                                          : elapsed_ext[ueg_pkg::WIDTH_W-1:0];
          if (elapsed_ext > CMP_W'(cfg.gap_pulse_threshold)) begin
            if (gap_run != ueg_pkg::GAP_RUN_MAX) begin
              gap_run_next = gap_run + 1'b1;
            end
          end else begin
            gap_run_next = '0;
          end
          gap_flag_next    = (gap_run_next >= cfg.gap_confirm_count);
          phase_next       = ueg_pkg::PH_IDLE;
          phase_ticks_next = '0;
        end else if (elapsed_ext >= CMP_W'(cfg.echo_timeout_ticks)) begin
          tmo              = 1'b1;
          phase_next       = ueg_pkg::PH_IDLE;
          phase_ticks_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.trigger_level  = (phase_next == ueg_pkg::PH_TRIG);
    res.reading_done   = done;
    res.echo_width_us  = width;
    res.echo_timed_out = tmo;
    res.gap_run_length = gap_run_next;
    res.gap_detected   = gap_flag_next;
  end

endmodule

// ----- rtl/ueg_out_reg.sv -----
`timescale 1ns / 1ps
// Result register between the sequencer and the result channel.
// Depends on ueg_pkg for the result beat layout.
module ueg_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ueg_pkg::res_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ueg_pkg::res_t out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

// ----- rtl/ultrasonic_echo_ranging_gap_detector.sv -----
`timescale 1ns / 1ps
// Channel   Role    Beat contents
// sample    sink    echo_level, one beat per microsecond tick
// result    source  trigger_level, reading_done, echo_width_us, echo_timed_out,
//                   gap_run_length, gap_detected
// cfg       sink    index, data; always ready
// Each tick beat is worked combinationally and its result is registered, so a beat
// is taken every cycle while the result register can accept it, and a result
// leaves in the cycle after its tick. A stalled result register holds its beat
// and stops taking ticks only while it is full and not being read. Reset is
// synchronous and restores register defaults, idle phase, zero timer, zero gap run.
// Top level of the echo ranging gap detector; uses ueg_pkg, ueg_if.sv,
// ueg_cfg_regs, ueg_core and ueg_out_reg.
module ultrasonic_echo_ranging_gap_detector #(
  parameter int TRIGGER_TICKS = ueg_pkg::TRIGGER_TICKS_DEF,
  parameter int TIMER_BITS    = ueg_pkg::TIMER_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  ueg_sample_if.sink   sample,
  ueg_result_if.source result,
  ueg_cfg_if.sink      cfg
);

  ueg_pkg::cfg_t cfg_regs;
  ueg_pkg::res_t core_res;
  ueg_pkg::res_t out_res;
  logic          step;
  logic          stage_ready;

  assign cfg.ready    = 1'b1;
  assign sample.ready = stage_ready;
  assign step         = sample.valid && stage_ready;

  ueg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  ueg_core #(
    .TRIGGER_TICKS (TRIGGER_TICKS),
    .TIMER_BITS    (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .echo_level (sample.echo_level),
    .cfg        (cfg_regs),
    .res        (core_res)
  );

  ueg_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (stage_ready),
    .in_data   (core_res),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_res)
  );

  assign result.trigger_level  = out_res.trigger_level;
  assign result.reading_done   = out_res.reading_done;
  assign result.echo_width_us  = out_res.echo_width_us;
  assign result.echo_timed_out = out_res.echo_timed_out;
  assign result.gap_run_length = out_res.gap_run_length;
  assign result.gap_detected   = out_res.gap_detected;

endmodule

// ----- rtl/ueg_checker.sv -----
`timescale 1ns / 1ps
// Port checker for the echo ranging gap detector, bound to the top level.
// Depends on ueg_pkg for field widths.
module ueg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        trigger_level,
  input logic                        reading_done,
  input logic [ueg_pkg::WIDTH_W-1:0] echo_width_us,
  input logic                        echo_timed_out,
  input logic [ueg_pkg::RUN_W-1:0]   gap_run_length,
  input logic                        gap_detected
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(echo_width_us)
      && $stable(gap_run_length) && $stable(reading_done))
    else $error("result beat changed while stalled");

  a_end_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && (reading_done || echo_timed_out) |->
      !(reading_done && echo_timed_out) && !trigger_level)
    else $error("reading end overlaps a timeout or the trigger pulse");

  a_width_only_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (reading_done == (echo_width_us != '0)))
    else $error("echo width does not match reading completion");

  a_flag_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready ##1 res_valid && !reading_done |->
      $stable(gap_detected) || !$past(res_valid && res_ready, 1))
    else $error("gap flag changed without a completed reading");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind ultrasonic_echo_ranging_gap_detector ueg_checker u_ueg_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .trigger_level  (result.trigger_level),
  .reading_done   (result.reading_done),
  .echo_width_us  (result.echo_width_us),
  .echo_timed_out (result.echo_timed_out),
  .gap_run_length (result.gap_run_length),
  .gap_detected   (result.gap_detected)
);

// ----- bench/tb_ultrasonic_echo_ranging_gap_detector.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the echo ranging gap detector: a directed script, then shaped random
// echo pulses over several register settings, beats checked against typed or predicted beats.
// Depends on ueg_pkg, the channel interfaces in ueg_if.sv and the detector top level.
module tb_ultrasonic_echo_ranging_gap_detector;

  localparam logic [ueg_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'hC;

  typedef struct {
    bit                             is_write;
    logic [ueg_pkg::CFG_IDX_W-1:0]  idx;
    logic [ueg_pkg::CFG_DATA_W-1:0] data;
    logic                           echo;
    int                             reps;
    bit                             typed;
    ueg_pkg::res_t                  want;
  } script_row_t;

  typedef struct {
    logic [ueg_pkg::POLL_W-1:0] poll;
    logic [ueg_pkg::TMO_W-1:0]  timeout;
    logic [ueg_pkg::THR_W-1:0]  thresh;
    logic [ueg_pkg::CONF_W-1:0] confirm;
    int                         ticks;
    bit                         jitter;
  } range_setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ueg_sample_if sample();
  ueg_result_if result();
  ueg_cfg_if    cfg();

  ultrasonic_echo_ranging_gap_detector uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ueg_pkg::cfg_t                      shadow_regs;
  ueg_pkg::phase_t                    exp_phase;
  logic [ueg_pkg::TIMER_BITS_DEF-1:0] exp_timer;
  logic [ueg_pkg::RUN_W-1:0]          exp_run;
  logic                               exp_flag;
  ueg_pkg::res_t                      pending_results[$];
  bit                                 failed;
  bit                                 jitter;
  bit                                 plan_noise;
  int                                 plan_rise_after;
  int                                 plan_width;
  int                                 ready_hold;

  script_row_t script_rows [0:13] = '{
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b0, 1, 1'b1, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b1, 1, 1'b1, '0},
    '{1'b1, ueg_pkg::REG_POLL, 24'd0, 1'b0, 0, 1'b0, '0},
    '{1'b1, ueg_pkg::REG_TIMEOUT, 24'hA50000, 1'b0, 0, 1'b0, '0},
    '{1'b1, ueg_pkg::REG_THRESH, 24'h5A0000, 1'b0, 0, 1'b0, '0},
    '{1'b1, ueg_pkg::REG_CONFIRM, 24'h123400, 1'b0, 0, 1'b0, '0},
    '{1'b1, REG_SPARE, 24'hFFFFFF, 1'b0, 0, 1'b0, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b0, 1, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b0, 9, 1'b0, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b1, 1, 1'b0, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b1, 8'd0, 1'b0}},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b1, 11, 1'b0, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b1, 1, 1'b0, '0},
    '{1'b0, ueg_pkg::REG_POLL, 24'd0, 1'b0, 1, 1'b1, '{1'b0, 1'b1, 16'd1, 1'b0, 8'd1, 1'b1}}
  };

  function automatic ueg_pkg::res_t advance_ranger(input logic lvl);
    logic [ueg_pkg::TIMER_BITS_DEF-1:0] el;
    ueg_pkg::res_t r;
    el = exp_timer;
    if (el != '1) el = el + 1'b1;
    exp_timer = el;
    r = '0;
    case (exp_phase)
      ueg_pkg::PH_IDLE: begin
        if (el >= shadow_regs.poll_interval_ticks) begin
          exp_phase = ueg_pkg::PH_TRIG;
          exp_timer = '0;
        end
      end
      ueg_pkg::PH_TRIG: begin
        if (el >= ueg_pkg::TRIGGER_TICKS_DEF) begin
          exp_phase = ueg_pkg::PH_RISE;
          exp_timer = '0;
        end
      end
      ueg_pkg::PH_RISE: begin
        if (lvl) begin
          exp_phase = ueg_pkg::PH_FALL;
          exp_timer = '0;
        end else if (el >= shadow_regs.echo_timeout_ticks) begin
          r.echo_timed_out = 1'b1;
          exp_phase = ueg_pkg::PH_IDLE;
          exp_timer = '0;
        end
      end
      default: begin
        if (!lvl) begin
          r.reading_done = 1'b1;
          r.echo_width_us = (el > 24'h00FFFF) ? ueg_pkg::WIDTH_MAX : el[ueg_pkg::WIDTH_W-1:0];
          if (el > shadow_regs.gap_pulse_threshold) begin
            if (exp_run != ueg_pkg::GAP_RUN_MAX) exp_run = exp_run + 1'b1;
          end else begin
            exp_run = '0;
          end
          exp_flag = (exp_run >= shadow_regs.gap_confirm_count);
          exp_phase = ueg_pkg::PH_IDLE;
          exp_timer = '0;
        end else if (el >= shadow_regs.echo_timeout_ticks) begin
          r.echo_timed_out = 1'b1;
          exp_phase = ueg_pkg::PH_IDLE;
          exp_timer = '0;
        end
      end
    endcase
    r.trigger_level = (exp_phase == ueg_pkg::PH_TRIG);
    r.gap_run_length = exp_run;
    r.gap_detected = exp_flag;
    return r;
  endfunction

  // Each time the trigger ends, choose how the next echo will look: when it rises and how wide.
  function automatic void plan_pulse();
    int thr;
    int tmo;
    int pick;
    thr = int'(shadow_regs.gap_pulse_threshold);
    tmo = int'(shadow_regs.echo_timeout_ticks);
    plan_noise = ($urandom_range(0, 9) == 0);
    if (tmo <= 64 && $urandom_range(0, 7) == 0)
      plan_rise_after = tmo + $urandom_range(0, 2);
    else
      plan_rise_after = $urandom_range(0, (tmo < 6) ? tmo : 6);
    pick = $urandom_range(0, 9);
    if (pick < 4) plan_width = thr + 1;
    else if (pick < 7) plan_width = thr;
    else if (pick < 8 && tmo <= 64) plan_width = tmo + 1 + $urandom_range(0, 1);
    else plan_width = $urandom_range(1, thr + 3);
    if (plan_width < 1) plan_width = 1;
  endfunction

  function automatic logic pick_echo();
    case (exp_phase)
      ueg_pkg::PH_RISE:
        return plan_noise ? 1'($urandom_range(0, 1)) : (int'(exp_timer) >= plan_rise_after);
      ueg_pkg::PH_FALL:
        return plan_noise ? 1'($urandom_range(0, 1)) : (int'(exp_timer) + 1 < plan_width);
      default: return ($urandom_range(0, 7) == 0);
    endcase
  endfunction

  task automatic send_tick(input logic lvl, input bit typed, input ueg_pkg::res_t want);
    ueg_pkg::res_t model_out;
    ueg_pkg::phase_t was;
    if (jitter && $urandom_range(0, 3) == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.echo_level <= lvl;
    do @(posedge clk); while (sample.ready !== 1'b1);
    was = exp_phase;
    model_out = advance_ranger(lvl);
    pending_results.push_back(typed ? want : model_out);
    if (was != ueg_pkg::PH_RISE && exp_phase == ueg_pkg::PH_RISE) plan_pulse();
  endtask

  task automatic write_reg(input logic [ueg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ueg_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (idx)
      ueg_pkg::REG_POLL:    shadow_regs.poll_interval_ticks = data[ueg_pkg::POLL_W-1:0];
      ueg_pkg::REG_TIMEOUT: shadow_regs.echo_timeout_ticks = data[ueg_pkg::TMO_W-1:0];
      ueg_pkg::REG_THRESH:  shadow_regs.gap_pulse_threshold = data[ueg_pkg::THR_W-1:0];
      ueg_pkg::REG_CONFIRM: shadow_regs.gap_confirm_count = data[ueg_pkg::CONF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    sample.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    failed = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ready_hold = 0;
      result.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      result.ready <= 1'b0;
    end else if (jitter && $urandom_range(0, 4) == 0) begin
      ready_hold = $urandom_range(0, 2);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ueg_pkg::res_t got;
    ueg_pkg::res_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      got.trigger_level = result.trigger_level;
      got.reading_done = result.reading_done;
      got.echo_width_us = result.echo_width_us;
      got.echo_timed_out = result.echo_timed_out;
      got.gap_run_length = result.gap_run_length;
      got.gap_detected = result.gap_detected;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual %p", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.trigger_level !== want.trigger_level)
          report_field("trigger_level", 16'(want.trigger_level), 16'(got.trigger_level));
        if (got.reading_done !== want.reading_done)
          report_field("reading_done", 16'(want.reading_done), 16'(got.reading_done));
        if (got.echo_width_us !== want.echo_width_us)
          report_field("echo_width_us", want.echo_width_us, got.echo_width_us);
        if (got.echo_timed_out !== want.echo_timed_out)
          report_field("echo_timed_out", 16'(want.echo_timed_out), 16'(got.echo_timed_out));
        if (got.gap_run_length !== want.gap_run_length)
          report_field("gap_run_length", 16'(want.gap_run_length), 16'(got.gap_run_length));
        if (got.gap_detected !== want.gap_detected)
          report_field("gap_detected", 16'(want.gap_detected), 16'(got.gap_detected));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_ultrasonic_echo_ranging_gap_detector failed");
    $finish;
  end

  initial begin
    range_setting_t settings [0:6];
    range_setting_t s;
    sample.valid <= 1'b0;
    sample.echo_level <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= ueg_pkg::REG_POLL;
    cfg.data <= '0;
    shadow_regs = '{ueg_pkg::POLL_RESET, ueg_pkg::TIMEOUT_RESET,
                    ueg_pkg::THRESH_RESET, ueg_pkg::CONFIRM_RESET};
    exp_phase = ueg_pkg::PH_IDLE;
    exp_timer = '0;
    exp_run = '0;
    exp_flag = 1'b0;
    failed = 1'b0;
    jitter = 1'b1;
    plan_noise = 1'b0;
    plan_rise_after = 0;
    plan_width = 1;

    settings[0] = '{24'd3, 16'd20, 16'd5, 8'd2, 150, 1'b1};
    settings[1] = '{ueg_pkg::POLL_W'($urandom_range(0, 15)),
                    ueg_pkg::TMO_W'($urandom_range(1, 30)),
                    ueg_pkg::THR_W'($urandom_range(0, 15)),
                    ueg_pkg::CONF_W'($urandom_range(0, 5)), 150, 1'b1};
    settings[2] = '{24'd0, 16'd3, 16'd0, 8'd255, 160, 1'b0};
    settings[3] = '{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 60, 1'b1};
    settings[4] = '{24'd0, 16'd40, 16'd12, 8'd1, 150, 1'b0};
    settings[5] = '{24'd1, 16'd3, 16'd1, 8'd1, 100, 1'b1};
    settings[6] = '{24'd2, 16'd16, 16'd4, 8'd3, 100, 1'b0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script_rows[i]) begin
      if (script_rows[i].is_write) begin
        if (i == 0 || !script_rows[i - 1].is_write) settle();
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        cfg.valid <= 1'b0;
        repeat (script_rows[i].reps)
          send_tick(script_rows[i].echo, script_rows[i].typed, script_rows[i].want);
      end
    end

    foreach (settings[p]) begin
      s = settings[p];
      settle();
      write_reg(ueg_pkg::REG_POLL, s.poll);
      write_reg(ueg_pkg::REG_TIMEOUT, {8'($urandom), s.timeout});
      write_reg(ueg_pkg::REG_THRESH, {8'($urandom), s.thresh});
      write_reg(ueg_pkg::REG_CONFIRM, {16'($urandom), s.confirm});
      cfg.valid <= 1'b0;
      jitter = s.jitter;
      for (int n = 0; n < s.ticks; n++) begin
        if (p == 1 && n == s.ticks / 2) settle();
        send_tick(pick_echo(), 1'b0, '0);
      end
    end

    settle();
    if (!failed) begin
      $display("tb_ultrasonic_echo_ranging_gap_detector passed");
    end else begin
      $display("tb_ultrasonic_echo_ranging_gap_detector failed");
    end
    $finish;
  end

endmodule
